FILE: rtl/pwr_sup_pkg.sv
// Package for the power-saver and battery supervisor.
// Holds field widths, register indexes and countdown scale constants.
// No dependencies.
package pwr_sup_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_OFF  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKLIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STANDBY   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_BL    = 2'd3;

  // Register and state widths.
  localparam int AUTO_MIN_W  = 7;
  localparam int SECONDS_W   = 8;
  localparam int CHECK_W     = 4;
  localparam int RUN_W       = 8;
  localparam int ELAPSED_W   = 5;
  localparam int AUTO_LEFT_W = 16;
  localparam int SAVER_W     = 12;
  localparam int AUTO_PROD_W = 17;

  // Ticks per minute and per second at a 100 ms tick.
  localparam logic [AUTO_PROD_W-1:0] TICKS_PER_MIN = 17'd600;
  localparam logic [SAVER_W-1:0]     TICKS_PER_SEC = 12'd10;

  // Saturation limits.
  localparam logic [RUN_W-1:0]       RUN_MAX     = 8'hFF;
  localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX = 5'h1F;
  localparam logic [AUTO_LEFT_W-1:0] AUTO_MAX    = 16'hFFFF;

  // Outputs held from tick to tick.
  typedef struct packed {
    logic backlight_on;
    logic backlight_enable;
    logic suspend;
    logic low_batt_indicator;
  } held_t;

endpackage

FILE: rtl/power_saver_battery_supervisor.sv
// Power-saver and battery supervisor, one tick beat per 100 ms.
// Depends on pwr_sup_pkg for widths, register indexes and the held-output type.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid / in_stall    power_key .. batt_low (6 bits)
//   out       source     out_valid / out_stall  power_off .. batt_warning (6 bits)
//   cfg       sink       cfg_write              cfg_index, cfg_data
//
// Each tick beat is handled in one pass: the next state and the result are computed from
// the state registers and the beat together and land in the result register.
// A new beat is taken every cycle unless the result register holds an untaken beat.
// Reset clears all state but the result payload; the battery check countdown starts at CHECK_INTERVAL.
// While out_stall holds a result, in_stall is raised and the state is frozen.
module power_saver_battery_supervisor #(
  parameter int unsigned CHECK_INTERVAL = 10,
  parameter int unsigned CUTOFF_LIMIT   = 5,
  parameter int unsigned SHUTDOWN_DELAY = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port.
  input  logic                               cfg_write,
  input  logic [pwr_sup_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pwr_sup_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Tick channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               power_key,
  input  logic                               key_pressed,
  input  logic                               weight_stable,
  input  logic                               weight_at_zero,
  input  logic                               batt_cutoff,
  input  logic                               batt_low,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               power_off,
  output logic                               backlight_on,
  output logic                               backlight_enable,
  output logic                               suspend,
  output logic                               low_batt_indicator,
  output logic                               batt_warning
);
  import pwr_sup_pkg::*;

  localparam logic [CHECK_W-1:0]   CHECK_RELOAD = CHECK_W'(CHECK_INTERVAL);
  localparam logic [RUN_W-1:0]     RUN_LIMIT    = RUN_W'(CUTOFF_LIMIT);
  localparam logic [ELAPSED_W-1:0] DELAY_LIMIT  = ELAPSED_W'(SHUTDOWN_DELAY);

  // Configuration registers.
  logic [AUTO_MIN_W-1:0] auto_off_minutes;
  logic [SECONDS_W-1:0]  backlight_off_seconds;
  logic [SECONDS_W-1:0]  standby_seconds;
  logic                  low_batt_backlight_off;

  // Supervisor state.
  logic [CHECK_W-1:0]     check_countdown, check_countdown_next;
  logic [RUN_W-1:0]       cutoff_run, cutoff_run_next;
  logic                   shutdown_pending, shutdown_pending_next;
  logic [ELAPSED_W-1:0]   shutdown_elapsed, shutdown_elapsed_next;
  logic [AUTO_LEFT_W-1:0] auto_off_left, auto_off_left_next;
  logic [SAVER_W-1:0]     backlight_left, backlight_left_next;
  logic [SAVER_W-1:0]     standby_left, standby_left_next;
  logic                   saver_started, saver_started_next;
  logic                   off_latched, off_latched_next;
  held_t                  held, held_next;
  logic                   warn_next;

  logic                   in_accept;

  // Reload values for the three countdowns.
  logic [AUTO_PROD_W-1:0] auto_prod;
  logic [AUTO_LEFT_W-1:0] auto_reload;
  logic [SAVER_W-1:0]     backlight_reload;
  logic [SAVER_W-1:0]     standby_reload;

  assign auto_prod        = AUTO_PROD_W'(auto_off_minutes) * TICKS_PER_MIN;
  assign auto_reload      = (auto_prod > AUTO_PROD_W'(AUTO_MAX)) ? AUTO_MAX
                                                                 : auto_prod[AUTO_LEFT_W-1:0];
  assign backlight_reload = SAVER_W'(backlight_off_seconds) * TICKS_PER_SEC;
  assign standby_reload   = SAVER_W'(standby_seconds) * TICKS_PER_SEC;

  // The result register parts the two sides; a beat enters when it is free.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_off_minutes       <= '0;
      backlight_off_seconds  <= '0;
      standby_seconds        <= '0;
      low_batt_backlight_off <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AUTO_OFF:  auto_off_minutes       <= cfg_data[AUTO_MIN_W-1:0];
        REG_BACKLIGHT: backlight_off_seconds  <= cfg_data;
        REG_STANDBY:   standby_seconds        <= cfg_data;
        REG_LOW_BL:    low_batt_backlight_off <= cfg_data[0];
      endcase
    end
  end

  // One tick: power key, countdowns, cutoff timing, battery check, reloads, tests.
  always_comb begin
    logic done;
    logic reload_all;
    logic reload_standby;

    check_countdown_next  = check_countdown;
    cutoff_run_next       = cutoff_run;
    shutdown_pending_next = shutdown_pending;
    shutdown_elapsed_next = shutdown_elapsed;
    auto_off_left_next    = auto_off_left;
    backlight_left_next   = backlight_left;
    standby_left_next     = standby_left;
    saver_started_next    = saver_started;
    off_latched_next      = off_latched;
    held_next             = held;
    warn_next             = 1'b0;
    done                  = off_latched;
    reload_all            = 1'b0;
    reload_standby        = 1'b0;

    if (!done && power_key) begin
      off_latched_next = 1'b1;
      done             = 1'b1;
    end

    if (!done) begin
      // Countdowns step down toward zero.
      if (auto_off_left != '0) auto_off_left_next = auto_off_left - 1'b1;
      if (backlight_left != '0) backlight_left_next = backlight_left - 1'b1;
      if (standby_left != '0) standby_left_next = standby_left - 1'b1;

      // A pending cutoff shutdown powers off once its delay has run out.
      if (shutdown_pending) begin
        if (shutdown_elapsed != ELAPSED_MAX) shutdown_elapsed_next = shutdown_elapsed + 1'b1;
        if (shutdown_elapsed_next > DELAY_LIMIT) begin
          off_latched_next = 1'b1;
          done             = 1'b1;
        end
      end
    end

    if (!done) begin
      // Periodic battery check.
      if (check_countdown == '0) begin
        check_countdown_next = CHECK_RELOAD;
        if (batt_cutoff) begin
          if (cutoff_run != RUN_MAX) cutoff_run_next = cutoff_run + 1'b1;
        end else begin
          cutoff_run_next = '0;
        end
        if (!shutdown_pending && (cutoff_run_next > RUN_LIMIT)) begin
          shutdown_pending_next = 1'b1;
          shutdown_elapsed_next = '0;
          warn_next             = 1'b1;
        end
        held_next.low_batt_indicator = batt_low;
        held_next.backlight_enable   = ~(batt_low & low_batt_backlight_off);
      end else begin
        check_countdown_next = check_countdown - 1'b1;
      end

      // The first tick starts the saver with a full reload.
      if (!saver_started) begin
        saver_started_next     = 1'b1;
        held_next.backlight_on = (backlight_off_seconds != '0);
      end

      // Reload rules.
      reload_all     = ~saver_started | key_pressed | ~weight_stable;
      reload_standby = reload_all | ~weight_at_zero;
      if (reload_all && (auto_off_minutes != '0)) auto_off_left_next = auto_reload;
      if (reload_all) backlight_left_next = backlight_reload;
      if (reload_standby && (standby_seconds != '0)) standby_left_next = standby_reload;

      // Timeout tests.
      if ((auto_off_minutes != '0) && (auto_off_left_next == '0)) begin
        off_latched_next = 1'b1;
      end else begin
        if (backlight_off_seconds > SECONDS_W'(1)) begin
          held_next.backlight_on = (backlight_left_next != '0);
        end
        if (standby_seconds != '0) begin
          held_next.suspend = (standby_left_next == '0);
        end
      end
    end
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_countdown  <= CHECK_RELOAD;
      cutoff_run       <= '0;
      shutdown_pending <= 1'b0;
      shutdown_elapsed <= '0;
      auto_off_left    <= '0;
      backlight_left   <= '0;
      standby_left     <= '0;
      saver_started    <= 1'b0;
      off_latched      <= 1'b0;
      held             <= '0;
    end else if (in_accept) begin
      check_countdown  <= check_countdown_next;
      cutoff_run       <= cutoff_run_next;
      shutdown_pending <= shutdown_pending_next;
      shutdown_elapsed <= shutdown_elapsed_next;
      auto_off_left    <= auto_off_left_next;
      backlight_left   <= backlight_left_next;
      standby_left     <= standby_left_next;
      saver_started    <= saver_started_next;
      off_latched      <= off_latched_next;
      held             <= held_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      power_off          <= off_latched_next;
      backlight_on       <= held_next.backlight_on;
      backlight_enable   <= held_next.backlight_enable;
      suspend            <= held_next.suspend;
      low_batt_indicator <= held_next.low_batt_indicator;
      batt_warning       <= warn_next;
    end
  end

  // Power-off never clears once latched.
  a_off_sticky: assert property (@(posedge clk) disable iff (rst)
    off_latched |=> off_latched)
    else $error("power-off latch cleared");

  // A beat taken after power-off repeats power_off with no warning.
  a_off_repeat: assert property (@(posedge clk) disable iff (rst)
    (in_accept && off_latched) |=> (out_valid && power_off && !batt_warning))
    else $error("latched power-off beat carries wrong result");

  // A warning result always goes with a pending cutoff shutdown.
  a_warn_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && batt_warning) |-> shutdown_pending)
    else $error("battery warning without pending shutdown");

  // The check countdown never exceeds its reload value.
  a_check_range: assert property (@(posedge clk) disable iff (rst)
    check_countdown <= CHECK_RELOAD)
    else $error("battery check countdown out of range");

endmodule

FILE: sim/supervisor_tb_pkg.sv
`timescale 1ns / 1ps
// Beat types and the status scoreboard for the power-saver supervisor testbench.
// Depends on pwr_sup_pkg for widths, register indexes and the held-output type.
package supervisor_tb_pkg;
  import pwr_sup_pkg::*;

  // Parameters the block is built with in this testbench.
  localparam int CHECK_TICKS    = 10;
  localparam int CUTOFF_RUNS    = 5;
  localparam int SHUTDOWN_TICKS = 20;

  // One tick beat, in port order.
  typedef struct packed {
    logic power_key;
    logic key_pressed;
    logic weight_stable;
    logic weight_at_zero;
    logic batt_cutoff;
    logic batt_low;
  } tick_t;

  // One status beat, in port order.
  typedef struct packed {
    logic power_off;
    logic backlight_on;
    logic backlight_enable;
    logic suspend;
    logic low_batt_indicator;
    logic batt_warning;
  } status_t;

  class supervisor_scoreboard;
    // Copies of the configuration registers.
    logic [AUTO_MIN_W-1:0]  auto_minutes;
    logic [SECONDS_W-1:0]   backlight_secs;
    logic [SECONDS_W-1:0]   standby_secs;
    logic                   low_batt_dark;
    // Supervisor state as the block should hold it.
    logic [CHECK_W-1:0]     check_count;
    logic [RUN_W-1:0]       cutoff_run;
    logic                   off_pending;
    logic [ELAPSED_W-1:0]   off_elapsed;
    logic [AUTO_LEFT_W-1:0] auto_left;
    logic [SAVER_W-1:0]     backlight_left;
    logic [SAVER_W-1:0]     standby_left;
    logic                   saver_running;
    logic                   supply_off;
    held_t                  held;
    // Status beats still owed by the block, oldest first.
    status_t                status_due[$];
    int                     mismatches;
    int                     beats_seen;

    function new();
      auto_minutes   = '0;
      backlight_secs = '0;
      standby_secs   = '0;
      low_batt_dark  = 1'b0;
      check_count    = CHECK_W'(CHECK_TICKS);
      cutoff_run     = '0;
      off_pending    = 1'b0;
      off_elapsed    = '0;
      auto_left      = '0;
      backlight_left = '0;
      standby_left   = '0;
      saver_running  = 1'b0;
      supply_off     = 1'b0;
      held           = '0;
      mismatches     = 0;
      beats_seen     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_AUTO_OFF:  auto_minutes   = data[AUTO_MIN_W-1:0];
        REG_BACKLIGHT: backlight_secs = data[SECONDS_W-1:0];
        REG_STANDBY:   standby_secs   = data[SECONDS_W-1:0];
        REG_LOW_BL:    low_batt_dark  = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // Reload the countdowns; a steady non-zero weight reloads standby only.
    function void load_countdowns(bit every_count);
      logic [AUTO_PROD_W-1:0] ticks;
      if (every_count && auto_minutes != 0) begin
        ticks = AUTO_PROD_W'(auto_minutes) * TICKS_PER_MIN;
        auto_left = (ticks > AUTO_PROD_W'(AUTO_MAX)) ? AUTO_MAX : ticks[AUTO_LEFT_W-1:0];
      end
      if (every_count)
        backlight_left = SAVER_W'(backlight_secs) * TICKS_PER_SEC;
      if (standby_secs != 0)
        standby_left = SAVER_W'(standby_secs) * TICKS_PER_SEC;
    endfunction

    function status_t status_now(logic warn);
      status_t s;
      s.power_off          = supply_off;
      s.backlight_on       = held.backlight_on;
      s.backlight_enable   = held.backlight_enable;
      s.suspend            = held.suspend;
      s.low_batt_indicator = held.low_batt_indicator;
      s.batt_warning       = warn;
      return s;
    endfunction

    // Advance the supervisor by one tick and return the status it reports.
    function status_t advance(tick_t t);
      logic warn;
      warn = 1'b0;
      if (supply_off)
        return status_now(1'b0);
      if (t.power_key) begin
        supply_off = 1'b1;
        return status_now(1'b0);
      end

      // Countdowns step down first.
      if (auto_left != 0) auto_left--;
      if (backlight_left != 0) backlight_left--;
      if (standby_left != 0) standby_left--;

      // A pending cutoff shutdown is timed.
      if (off_pending) begin
        if (off_elapsed != ELAPSED_MAX) off_elapsed++;
        if (off_elapsed > SHUTDOWN_TICKS) begin
          supply_off = 1'b1;
          return status_now(1'b0);
        end
      end

      // Battery check when its countdown runs out.
      if (check_count == 0) begin
        check_count = CHECK_W'(CHECK_TICKS);
        if (t.batt_cutoff) begin
          if (cutoff_run != RUN_MAX) cutoff_run++;
        end else begin
          cutoff_run = '0;
        end
        if (!off_pending && cutoff_run > CUTOFF_RUNS) begin
          off_pending = 1'b1;
          off_elapsed = '0;
          warn = 1'b1;
        end
        held.low_batt_indicator = t.batt_low;
        held.backlight_enable   = !(t.batt_low && low_batt_dark);
      end else begin
        check_count--;
      end

      // The saver starts on the first tick.
      if (!saver_running) begin
        saver_running = 1'b1;
        held.backlight_on = (backlight_secs != 0);
        load_countdowns(1'b1);
      end

      if (t.key_pressed || !t.weight_stable)
        load_countdowns(1'b1);
      else if (!t.weight_at_zero)
        load_countdowns(1'b0);

      // Timeout tests.
      if (auto_minutes != 0 && auto_left == 0) begin
        supply_off = 1'b1;
        return status_now(warn);
      end
      if (backlight_secs > 1)
        held.backlight_on = (backlight_left != 0);
      if (standby_secs != 0)
        held.suspend = (standby_left == 0);
      return status_now(warn);
    endfunction

    function void note_tick(tick_t t);
      status_due.push_back(advance(t));
    endfunction

    task report(string what);
      $display("MISMATCH at status beat %0d: %s", beats_seen, what);
      mismatches++;
    endtask

    task compare_bit(string field, logic got, logic want);
      if (got !== want)
        report($sformatf("%s is %b, should be %b", field, got, want));
    endtask

    task check_status(status_t got);
      status_t want;
      beats_seen++;
      if (status_due.size() == 0) begin
        report($sformatf("status beat %b arrived with none owed", got));
        return;
      end
      want = status_due.pop_front();
      compare_bit("power_off", got.power_off, want.power_off);
      compare_bit("backlight_on", got.backlight_on, want.backlight_on);
      compare_bit("backlight_enable", got.backlight_enable, want.backlight_enable);
      compare_bit("suspend", got.suspend, want.suspend);
      compare_bit("low_batt_indicator", got.low_batt_indicator, want.low_batt_indicator);
      compare_bit("batt_warning", got.batt_warning, want.batt_warning);
    endtask
  endclass

endpackage

FILE: sim/power_saver_battery_supervisor_test.sv
`timescale 1ns / 1ps
// Top-level testbench for the power-saver and battery supervisor.
// Depends on pwr_sup_pkg, supervisor_tb_pkg and the block itself.
module power_saver_battery_supervisor_test;
  import pwr_sup_pkg::*;
  import supervisor_tb_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_TICKS = 220;

  // Ways the supply is finally shut down.
  typedef enum int {END_BY_KEY, END_BY_AUTO_OFF, END_BY_CUTOFF} shutdown_way_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   power_key = 1'b0;
  logic                   key_pressed = 1'b0;
  logic                   weight_stable = 1'b0;
  logic                   weight_at_zero = 1'b0;
  logic                   batt_cutoff = 1'b0;
  logic                   batt_low = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   power_off;
  logic                   backlight_on;
  logic                   backlight_enable;
  logic                   suspend;
  logic                   low_batt_indicator;
  logic                   batt_warning;

  supervisor_scoreboard board;
  int send_gap_max = 14;
  int recv_gap_max = 14;
  int quiet_left = 0;

  power_saver_battery_supervisor #(
    .CHECK_INTERVAL(CHECK_TICKS),
    .CUTOFF_LIMIT(CUTOFF_RUNS),
    .SHUTDOWN_DELAY(SHUTDOWN_TICKS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .power_key(power_key),
    .key_pressed(key_pressed),
    .weight_stable(weight_stable),
    .weight_at_zero(weight_at_zero),
    .batt_cutoff(batt_cutoff),
    .batt_low(batt_low),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_off(power_off),
    .backlight_on(backlight_on),
    .backlight_enable(backlight_enable),
    .suspend(suspend),
    .low_batt_indicator(low_batt_indicator),
    .batt_warning(batt_warning)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Write all four registers back to back while the block is idle.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] auto_data,
                              input logic [CFG_DATA_W-1:0] bl_data,
                              input logic [CFG_DATA_W-1:0] sb_data,
                              input logic [CFG_DATA_W-1:0] low_data);
    logic [CFG_INDEX_W-1:0] indexes[4];
    logic [CFG_DATA_W-1:0]  values[4];
    indexes = '{REG_AUTO_OFF, REG_BACKLIGHT, REG_STANDBY, REG_LOW_BL};
    values  = '{auto_data, bl_data, sb_data, low_data};
    cfg_write <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= indexes[i];
      cfg_data  <= values[i];
      @(posedge clk);
      board.set_reg(indexes[i], values[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Offer one tick beat after a random gap and wait until it is taken.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    power_key      <= t.power_key;
    key_pressed    <= t.key_pressed;
    weight_stable  <= t.weight_stable;
    weight_at_zero <= t.weight_at_zero;
    batt_cutoff    <= t.batt_cutoff;
    batt_low       <= t.batt_low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_tick(t);
  endtask

  // Stop sending and wait until every owed status beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Random tick that keeps the supply on: mostly quiet runs that let the
  // saver timers expire, mixed with key presses and unsteady weight.
  function automatic tick_t random_tick();
    tick_t t;
    t.power_key = 1'b0;
    if (quiet_left > 0) begin
      quiet_left--;
      t.key_pressed    = 1'b0;
      t.weight_stable  = 1'b1;
      t.weight_at_zero = ($urandom_range(0, 7) != 0);
    end else begin
      if ($urandom_range(0, 4) == 0) quiet_left = $urandom_range(1, 80);
      t.key_pressed    = ($urandom_range(0, 2) == 0);
      t.weight_stable  = 1'($urandom_range(0, 1));
      t.weight_at_zero = 1'($urandom_range(0, 1));
    end
    t.batt_cutoff = ($urandom_range(0, 3) != 0);
    t.batt_low    = 1'($urandom_range(0, 1));
    // Keep the cutoff run from passing its limit and keep auto-off from expiring.
    if (board.cutoff_run >= CUTOFF_RUNS) t.batt_cutoff = 1'b0;
    if (board.auto_minutes != 0 && board.auto_left < 100) t.key_pressed = 1'b1;
    return t;
  endfunction

  // Take status beats and stall the result channel at random.
  initial begin : status_sink
    int hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_status(status_t'({power_off, backlight_on, backlight_enable, suspend,
                                      low_batt_indicator, batt_warning}));
        hold = $urandom_range(0, recv_gap_max);
      end
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // Main stimulus.
  initial begin
    int auto_pick[PHASES];
    int bl_pick[PHASES];
    int sb_pick[PHASES];
    int pause_at;
    tick_t t;
    shutdown_way_t way;

    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: saturated auto-off, short timers, dark backlight on low battery.
    program_regs(8'hFF, 8'd2, 8'd1, 8'd1);
    for (int i = 0; i < 20; i++) begin
      t.power_key      = 1'b0;
      t.key_pressed    = (i % 3 == 0);
      t.weight_stable  = (i % 4 != 1);
      t.weight_at_zero = (i % 5 < 3);
      t.batt_cutoff    = (i >= 10);
      t.batt_low       = (i % 2 == 1) ^ (i >= 10);
      send_tick(t);
    end
    drain_results();

    // Random phases over several settings, extremes among them.
    auto_pick = '{0, 1, 109, 0, $urandom_range(1, 127), 127, $urandom_range(0, 127)};
    bl_pick   = '{0, 1, 255, 2, $urandom_range(2, 8), $urandom_range(2, 8),
                  $urandom_range(0, 8)};
    sb_pick   = '{0, 255, 1, $urandom_range(1, 6), $urandom_range(1, 6), 0,
                  $urandom_range(0, 6)};
    for (int p = 0; p < PHASES; p++) begin
      send_gap_max = (p % 2 == 0) ? 14 : 0;
      recv_gap_max = ((p / 2) % 2 == 0) ? 14 : 0;
      program_regs({1'($urandom_range(0, 1)), 7'(auto_pick[p])}, 8'(bl_pick[p]),
                   8'(sb_pick[p]), {7'($urandom_range(0, 127)), 1'(p % 2)});
      pause_at = $urandom_range(20, PHASE_TICKS - 20);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (i == pause_at) drain_results();
        send_tick(random_tick());
      end
      drain_results();
    end

    // Shut the supply down one of three ways.
    send_gap_max = 14;
    recv_gap_max = 14;
    way = shutdown_way_t'($urandom_range(0, 2));
    case (way)
      END_BY_KEY: begin
        t = random_tick();
        t.power_key = 1'b1;
        send_tick(t);
      end
      END_BY_AUTO_OFF: begin
        program_regs(8'd1, {1'b0, board.backlight_secs[6:0]} | 8'd2, 8'd3, 8'd0);
        t = '0;
        t.key_pressed   = 1'b1;
        t.weight_stable = 1'b1;
        send_tick(t);
        // A quiet scale until the one-minute countdown runs out.
        while (!board.supply_off) begin
          t = '0;
          t.weight_stable  = 1'b1;
          t.weight_at_zero = ($urandom_range(0, 3) != 0);
          t.batt_low       = 1'($urandom_range(0, 1));
          send_tick(t);
        end
      end
      default: begin
        // Battery stays below cutoff until the shutdown sequence ends.
        while (!board.supply_off) begin
          t = random_tick();
          t.key_pressed = 1'b1;
          t.batt_cutoff = 1'b1;
          send_tick(t);
        end
      end
    endcase

    // After power-off every beat only repeats the frozen status.
    for (int i = 0; i < 20; i++) begin
      t = tick_t'(6'($urandom_range(0, 63)));
      if (i == 0) t.power_key = 1'b1;
      send_tick(t);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d status beats never arrived", board.pending()));
    if (board.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: power_saver_battery_supervisor.f
rtl/pwr_sup_pkg.sv
rtl/power_saver_battery_supervisor.sv
sim/supervisor_tb_pkg.sv
sim/power_saver_battery_supervisor_test.sv
